// ===== rtl/core/dcdt_pkg.sv =====
// ----------------------------------------------------------------------------
// dcdt_pkg
// Shared types, register map codes and control bit positions of the dual
// down-counter timer.
// ----------------------------------------------------------------------------
package dcdt_pkg;

    localparam int DefNumTimers = 2;

    localparam int DataW  = 32;
    localparam int AddrW  = 12;
    localparam int CtlW   = 8;
    localparam int PreW   = 8;
    localparam int WordW  = 3;

    // Request kinds carried on the input side.
    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_TICK  = 2'd2,
        OP_NONE  = 2'd3
    } dcdt_op_t;

    // Word offsets inside one timer's 32-byte window.
    localparam logic [WordW-1:0] W_LOAD    = 3'd0;
    localparam logic [WordW-1:0] W_VALUE   = 3'd1;
    localparam logic [WordW-1:0] W_CONTROL = 3'd2;
    localparam logic [WordW-1:0] W_INTCLR  = 3'd3;
    localparam logic [WordW-1:0] W_RIS     = 3'd4;
    localparam logic [WordW-1:0] W_MIS     = 3'd5;
    localparam logic [WordW-1:0] W_BGLOAD  = 3'd6;

    // Control register bits.
    localparam int CTL_ONESHOT  = 0;
    localparam int CTL_32BIT    = 1;
    localparam int CTL_PRE_LO   = 2;
    localparam int CTL_IE       = 5;
    localparam int CTL_PERIODIC = 6;
    localparam int CTL_ENABLE   = 7;

    localparam logic [CtlW-1:0] CTL_RESET = 8'h20;

    // Prescale codes.
    localparam logic [1:0] PRE_DIV16  = 2'd1;
    localparam logic [1:0] PRE_DIV256 = 2'd2;

    localparam logic [DataW-1:0] FREE_RUN_32 = 32'hffff_ffff;
    localparam logic [DataW-1:0] FREE_RUN_16 = 32'h0000_ffff;

    // Offsets 0xFE0 and above hold the identification bytes.
    localparam logic [6:0] ID_BLOCK = 7'h7f;

    // Per-timer request, built by the address decoder.
    typedef struct packed {
        logic             wr;
        logic             tick;
        logic [WordW-1:0] word;
        logic [DataW-1:0] wdata;
    } dcdt_req_t;

    // Per-timer response: read data from the state before the request, and
    // the masked interrupt after it.
    typedef struct packed {
        logic [DataW-1:0] rdata;
        logic             irq;
    } dcdt_rsp_t;

    function automatic logic [DataW-1:0] reload_of(input logic [CtlW-1:0] ctl,
                                                   input logic [DataW-1:0] load);
        logic [DataW-1:0] r;
        if (!ctl[CTL_PERIODIC] && !ctl[CTL_ONESHOT])
        begin
            r = ctl[CTL_32BIT] ? FREE_RUN_32 : FREE_RUN_16;
        end
        else
        begin
            r = load;
        end
        return r;
    endfunction

    function automatic logic [PreW:0] prescale_div(input logic [1:0] code);
        logic [PreW:0] d;
        case (code)
            PRE_DIV16:  d = 9'd16;
            PRE_DIV256: d = 9'd256;
            default:    d = 9'd1;
        endcase
        return d;
    endfunction

    function automatic logic [7:0] id_byte(input logic [WordW-1:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h04;
            3'd1:    b = 8'h18;
            3'd2:    b = 8'h14;
            3'd3:    b = 8'h00;
            3'd4:    b = 8'h0d;
            3'd5:    b = 8'hf0;
            3'd6:    b = 8'h05;
            default: b = 8'hb1;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/core/dcdt_timer.sv =====
// ----------------------------------------------------------------------------
// dcdt_timer
// One down-counting timer: register state, prescaler, reload and interrupt.
// ----------------------------------------------------------------------------
module dcdt_timer
    import dcdt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  dcdt_req_t req,
    output dcdt_rsp_t rsp
);

    logic [CtlW-1:0]  ctl_reg,   ctl_next;
    logic [DataW-1:0] load_reg,  load_next;
    logic [DataW-1:0] count_reg, count_next;
    logic             raw_reg,   raw_next;
    logic [PreW-1:0]  pre_reg,   pre_next;
    logic             run_reg,   run_next;

    logic [DataW-1:0] rl;
    logic [PreW:0]    pre_inc;

    always_comb
    begin
        ctl_next   = ctl_reg;
        load_next  = load_reg;
        count_next = count_reg;
        raw_next   = raw_reg;
        pre_next   = pre_reg;
        run_next   = run_reg;
        rl         = reload_of(ctl_reg, load_reg);
        pre_inc    = {1'b0, pre_reg} + 9'd1;

        if (req.wr)
        begin
            case (req.word)
                W_LOAD:
                begin
                    load_next  = req.wdata;
                    rl         = reload_of(ctl_reg, req.wdata);
                    count_next = rl;
                    pre_next   = '0;
                    if (run_reg && rl == '0)
                    begin
                        raw_next = 1'b1;
                        run_next = 1'b0;
                    end
                end
                W_CONTROL:
                begin
                    ctl_next = req.wdata[CtlW-1:0];
                    pre_next = '0;
                    if (req.wdata[CTL_ENABLE])
                    begin
                        rl         = reload_of(req.wdata[CtlW-1:0], load_reg);
                        count_next = rl;
                        run_next   = 1'b1;
                        if (rl == '0)
                        begin
                            raw_next = 1'b1;
                            run_next = 1'b0;
                        end
                    end
                    else
                    begin
                        run_next = 1'b0;
                    end
                end
                W_INTCLR: raw_next  = 1'b0;
                W_BGLOAD: load_next = req.wdata;
                default:  ;
            endcase
        end
        else if (req.tick && run_reg)
        begin
            if (pre_inc < prescale_div(ctl_reg[CTL_PRE_LO +: 2]))
            begin
                pre_next = pre_inc[PreW-1:0];
            end
            else
            begin
                pre_next = '0;
                if (count_reg > 32'd1)
                begin
                    count_next = count_reg - 32'd1;
                end
                else
                begin
                    raw_next = 1'b1;
                    if (ctl_reg[CTL_ONESHOT])
                    begin
                        count_next = '0;
                        run_next   = 1'b0;
                    end
                    else
                    begin
                        // Expiry reloads; a zero reload stops the timer.
                        count_next = rl;
                        if (rl == '0)
                        begin
                            run_next = 1'b0;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg   <= CTL_RESET;
            load_reg  <= '0;
            count_reg <= '0;
            raw_reg   <= 1'b0;
            pre_reg   <= '0;
            run_reg   <= 1'b0;
        end
        else
        begin
            ctl_reg   <= ctl_next;
            load_reg  <= load_next;
            count_reg <= count_next;
            raw_reg   <= raw_next;
            pre_reg   <= pre_next;
            run_reg   <= run_next;
        end
    end

    always_comb
    begin
        case (req.word)
            W_LOAD, W_BGLOAD: rsp.rdata = load_reg;
            W_VALUE:          rsp.rdata = count_reg;
            W_CONTROL:        rsp.rdata = {{(DataW-CtlW){1'b0}}, ctl_reg};
            W_RIS:            rsp.rdata = {{(DataW-1){1'b0}}, raw_reg};
            W_MIS:            rsp.rdata = {{(DataW-1){1'b0}}, raw_reg & ctl_reg[CTL_IE]};
            default:          rsp.rdata = '0;
        endcase
        rsp.irq = raw_next & ctl_next[CTL_IE];
    end

    // The prescaler never runs past the /16 terminal count.
    a_pre16: assert property (@(posedge clk) disable iff (!rst_n)
        (run_reg && ctl_reg[CTL_PRE_LO +: 2] == PRE_DIV16) |-> pre_reg < 8'd16)
        else $error("prescaler beyond divide-by-16 range");

    // With no write and no tick, the timer state does not move.
    a_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (!req.wr && !req.tick) |=>
            $stable(count_reg) && $stable(ctl_reg) && $stable(raw_reg) && $stable(run_reg))
        else $error("timer state changed without a request");

endmodule

// ===== rtl/core/dual_down_counter_timer_unit.sv =====
// ----------------------------------------------------------------------------
// dual_down_counter_timer_unit
// Dual down-counting timer behind a 4 KiB register window, driven by a
// stream of read, write and tick requests.
// ----------------------------------------------------------------------------
// Each request on the input stream is a bus read, a bus write or a clock tick
// for one or both timers, and produces exactly one result carrying the read
// data and the masked interrupts after the request. The block takes one
// request per clock cycle unless the output stalls: a request is captured
// in an input register, the timer state and the result are computed from
// it as it moves on into the output register, and the result sits there
// until taken. The single input register lets one further request be
// taken while a result waits. Timer i occupies offsets 0x20*i to
// 0x20*i+0x1f; offsets 0xFE0 upwards read as identification bytes.
// ----------------------------------------------------------------------------
module dual_down_counter_timer_unit
    import dcdt_pkg::*;
#(
    parameter int NUM_TIMERS = DefNumTimers
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // addr [11:0], wdata [43:12], tick_mask [45:44], zero fill above.
    input  logic [47:0] s_axis_tdata,
    // op [1:0].
    input  logic [1:0]  s_axis_tuser,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // rdata [31:0], irq_timer0 [32], irq_timer1 [33], irq_combined [34],
    // zero fill above.
    output logic [39:0] m_axis_tdata
);

    // Input register holding the accepted request.
    logic             in_valid_reg;
    logic [1:0]       op_reg;
    logic [AddrW-1:0] addr_reg;
    logic [DataW-1:0] wdata_reg;
    logic [1:0]       mask_reg;

    // Output register holding the result.
    logic             out_valid_reg;
    logic [DataW-1:0] rdata_reg, rdata_next;
    logic [2:0]       irq_reg,   irq_next;

    logic             advance;
    logic             in_win;
    dcdt_req_t        req [2];
    dcdt_rsp_t        rsp [2];

    // The request moves on whenever the output register is free or emptying.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            op_reg    <= s_axis_tuser;
            addr_reg  <= s_axis_tdata[11:0];
            wdata_reg <= s_axis_tdata[43:12];
            mask_reg  <= s_axis_tdata[45:44];
        end
    end

    // Timer windows live below offset 0x40; bit 5 picks the timer.
    assign in_win = (addr_reg[AddrW-1:6] == '0);

    for (genvar i = 0; i < 2; i++)
    begin : g_timer
        if (i < NUM_TIMERS)
        begin : g_on
            assign req[i].wr    = advance && op_reg == OP_WRITE && in_win
                                  && addr_reg[5] == 1'(i);
            assign req[i].tick  = advance && op_reg == OP_TICK && mask_reg[i];
            assign req[i].word  = addr_reg[4:2];
            assign req[i].wdata = wdata_reg;

            dcdt_timer u_timer (
                .clk   (clk),
                .rst_n (rst_n),
                .req   (req[i]),
                .rsp   (rsp[i])
            );
        end
        else
        begin : g_off
            assign req[i]    = '0;
            assign rsp[i]    = '0;
        end
    end

    // Read data comes from the state before the request is applied.
    always_comb
    begin
        rdata_next = '0;
        case (op_reg)
            OP_READ:
            begin
                if (in_win)
                begin
                    rdata_next = addr_reg[5] ? rsp[1].rdata : rsp[0].rdata;
                end
                else if (addr_reg[AddrW-1:5] == ID_BLOCK)
                begin
                    rdata_next = {24'd0, id_byte(addr_reg[4:2])};
                end
            end
            default: rdata_next = '0;
        endcase
        irq_next = {rsp[0].irq | rsp[1].irq, rsp[1].irq, rsp[0].irq};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rdata_reg <= rdata_next;
            irq_reg   <= irq_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, irq_reg, rdata_reg};

    // A new result only ever follows a request held in the input register.
    a_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_valid_reg))
        else $error("result produced without a request");

    // Input back-pressure only when both registers are full and stalled.
    a_bp: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> in_valid_reg && out_valid_reg && !m_axis_tready)
        else $error("input stalled without cause");

    // The combined interrupt always tracks the two timer interrupts.
    a_irq: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> irq_reg[2] == (irq_reg[0] | irq_reg[1]))
        else $error("combined interrupt mismatch");

endmodule
